// File: design/quadratic_root_solver_assert.svh
// Assertion macros for the quadratic root solver.
// QRS_ASSERT is disabled while rst_n is low; QRS_ASSERT_ANY is checked always.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QRS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRS_ASSERT(lbl, prop, msg)
`define QRS_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// File: design/qrs_pkg.sv
package qrs_pkg;

  // Coefficient format.
  localparam int COEF_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_W     = 16;
  localparam int CNT_W     = 2;

  // Derived datapath widths.
  localparam int MAG_W  = COEF_W;
  localparam int PROD_W = 2 * COEF_W;
  localparam int D_W    = PROD_W + 1;
  localparam int SQ_W   = (D_W + 1) / 2;
  localparam int RAD_W  = 2 * SQ_W;
  localparam int N_W    = SQ_W + 1;
  localparam int NUM_W  = N_W + FRAC_BITS;
  localparam int DEN_W  = COEF_W + 1;

  // Root count codes.
  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;
  localparam logic [CNT_W-1:0] CNT_INF  = 2'd3;

  // Which quotients the divider has to form.
  typedef enum logic [1:0] {
    M_NONE,
    M_LIN,
    M_ONE,
    M_TWO
  } mode_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    mode_t            mode;
    logic             sa;
    logic             sb;
    logic             sc;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mc;
  } sq_side_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             neg1;
    logic             neg2;
  } dv_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] quo;
    logic [NUM_W-1:0] num;
  } dv_lane_t;

  // Magnitude of a two's complement coefficient; the most negative value maps to 2^(W-1).
  function automatic logic [MAG_W-1:0] mag_of(logic [COEF_W-1:0] v);
    logic [MAG_W-1:0] m;
    m = v[COEF_W-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

  // Clamp a quotient magnitude and apply its sign; the top bit is the saturation flag.
  function automatic logic [COEF_W:0] clamp_root(logic neg, logic [NUM_W-1:0] q);
    logic [NUM_W-1:0]  lim;
    logic [NUM_W-1:0]  m;
    logic              sat;
    logic [COEF_W-1:0] v;
    lim = neg ? (NUM_W'(1) << (COEF_W - 1)) : ((NUM_W'(1) << (COEF_W - 1)) - 1'b1);
    sat = (q > lim);
    m   = sat ? lim : q;
    v   = neg ? (~COEF_W'(m) + 1'b1) : COEF_W'(m);
    return {sat, v};
  endfunction

endpackage

// File: design/qrs_if.sv
// Configuration write channel.
interface qrs_cfg_if;
  import qrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] zero_tolerance;
  modport source(output valid, output zero_tolerance, input ready);
  modport sink(input valid, input zero_tolerance, output ready);
endinterface

// Coefficient input channel.
interface qrs_in_if;
  import qrs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [COEF_W-1:0] coef_c;
  modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// Root result channel.
interface qrs_out_if;
  import qrs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CNT_W-1:0]         root_count;
  logic signed [COEF_W-1:0] root_first;
  logic signed [COEF_W-1:0] root_second;
  logic                     saturated;
  modport source(output valid, output root_count, output root_first, output root_second,
                 output saturated, input ready);
  modport sink(input valid, input root_count, input root_first, input root_second,
               input saturated, output ready);
endinterface

// File: design/qrs_front.sv
module qrs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [qrs_pkg::COEF_W-1:0]   coef_a,
  input  logic [qrs_pkg::COEF_W-1:0]   coef_b,
  input  logic [qrs_pkg::COEF_W-1:0]   coef_c,
  input  logic [qrs_pkg::TOL_W-1:0]    tol,
  output logic                         out_vld,
  output qrs_pkg::sq_side_t            out_side,
  output logic [qrs_pkg::D_W-1:0]      out_dm
);
  import qrs_pkg::*;

  logic             s1_vld_r, s2_vld_r, s3_vld_r;
  logic             s1_sa_r, s1_sb_r, s1_sc_r;
  logic [MAG_W-1:0] s1_ma_r, s1_mb_r, s1_mc_r;
  logic             s1_as_r, s1_bs_r, s1_cs_r;
  logic             s2_sa_r, s2_sb_r, s2_sc_r;
  logic [MAG_W-1:0] s2_ma_r, s2_mb_r, s2_mc_r;
  logic             s2_as_r, s2_bs_r, s2_cs_r;
  logic [PROD_W-1:0] s2_bb_r, s2_ac_r;
  sq_side_t         s3_side_r, side_nxt;
  logic [D_W-1:0]   s3_dm_r, dm_nxt;
  logic [D_W-1:0]   bb, ac4, dm_tol;
  logic             dneg;
  logic [MAG_W-1:0] ma_in, mb_in, mc_in;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Stage 1: signs, magnitudes and the near-zero tests.
  assign ma_in = mag_of(coef_a);
  assign mb_in = mag_of(coef_b);
  assign mc_in = mag_of(coef_c);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sa_r <= coef_a[COEF_W-1];
      s1_sb_r <= coef_b[COEF_W-1];
      s1_sc_r <= coef_c[COEF_W-1];
      s1_ma_r <= ma_in;
      s1_mb_r <= mb_in;
      s1_mc_r <= mc_in;
      s1_as_r <= (ma_in <= MAG_W'(tol));
      s1_bs_r <= (mb_in <= MAG_W'(tol));
      s1_cs_r <= (mc_in <= MAG_W'(tol));
    end
  end

  // Stage 2: the two products of the discriminant.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_bb_r <= s1_mb_r * s1_mb_r;
      s2_ac_r <= s1_ma_r * s1_mc_r;
      s2_sa_r <= s1_sa_r;
      s2_sb_r <= s1_sb_r;
      s2_sc_r <= s1_sc_r;
      s2_ma_r <= s1_ma_r;
      s2_mb_r <= s1_mb_r;
      s2_mc_r <= s1_mc_r;
      s2_as_r <= s1_as_r;
      s2_bs_r <= s1_bs_r;
      s2_cs_r <= s1_cs_r;
    end
  end

  // Stage 3: discriminant magnitude and sign, then the case of the item.
  assign bb     = D_W'(s2_bb_r);
  assign ac4    = D_W'(s2_ac_r) << 2;
  assign dm_tol = D_W'(tol) << FRAC_BITS;

  always_comb begin
    dneg = 1'b0;
    if (s2_sa_r != s2_sc_r) begin
      dm_nxt = bb + ac4;
    end else if (bb >= ac4) begin
      dm_nxt = bb - ac4;
    end else begin
      dm_nxt = ac4 - bb;
      dneg   = 1'b1;
    end
  end

  always_comb begin
    side_nxt.sa = s2_sa_r;
    side_nxt.sb = s2_sb_r;
    side_nxt.sc = s2_sc_r;
    side_nxt.ma = s2_ma_r;
    side_nxt.mb = s2_mb_r;
    side_nxt.mc = s2_mc_r;
    if (s2_as_r) begin
      if (s2_bs_r) begin
        side_nxt.cnt  = s2_cs_r ? CNT_INF : CNT_NONE;
        side_nxt.mode = M_NONE;
      end else begin
        side_nxt.cnt  = CNT_ONE;
        side_nxt.mode = s2_cs_r ? M_NONE : M_LIN;
      end
    end else if (dm_nxt <= dm_tol) begin
      side_nxt.cnt  = CNT_ONE;
      side_nxt.mode = M_ONE;
    end else if (!dneg) begin
      side_nxt.cnt  = CNT_TWO;
      side_nxt.mode = M_TWO;
    end else begin
      side_nxt.cnt  = CNT_NONE;
      side_nxt.mode = M_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= side_nxt;
      s3_dm_r   <= dm_nxt;
    end
  end

  assign out_vld  = s3_vld_r;
  assign out_side = s3_side_r;
  assign out_dm   = s3_dm_r;

endmodule

// File: design/qrs_sqrt.sv
module qrs_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  qrs_pkg::sq_side_t         in_side,
  input  logic [qrs_pkg::D_W-1:0]   in_rad,
  output logic                      out_vld,
  output qrs_pkg::sq_side_t         out_side,
  output logic [qrs_pkg::SQ_W-1:0]  out_root
);
  import qrs_pkg::*;

  // One root bit per stage, most significant first; rem holds radicand minus root squared.
  logic             vld_r  [SQ_W];
  logic [RAD_W-1:0] rem_r  [SQ_W];
  logic [SQ_W-1:0]  root_r [SQ_W];
  sq_side_t         side_r [SQ_W];

  for (genvar j = 0; j < SQ_W; j++) begin : g_stage
    localparam int BIT = SQ_W - 1 - j;
    logic             vld_i;
    logic [RAD_W-1:0] rem_i;
    logic [SQ_W-1:0]  root_i;
    sq_side_t         side_i;
    logic [RAD_W-1:0] trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = RAD_W'(in_rad);
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign side_i = side_r[j-1];
    end

    // (r + 2^i)^2 <= V exactly when 2^(i+1)*r + 2^(2i) <= V - r^2.
    assign trial = (RAD_W'(root_i) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
    assign ge    = (rem_i >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? (rem_i - trial) : rem_i;
        root_r[j] <= ge ? (root_i | (SQ_W'(1) << BIT)) : root_i;
        side_r[j] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[SQ_W-1];
  assign out_side = side_r[SQ_W-1];
  assign out_root = root_r[SQ_W-1];

endmodule

// File: design/qrs_div.sv
module qrs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  qrs_pkg::dv_side_t          in_side,
  input  logic [qrs_pkg::NUM_W-1:0]  in_num1,
  input  logic [qrs_pkg::NUM_W-1:0]  in_num2,
  input  logic [qrs_pkg::DEN_W-1:0]  in_den,
  output logic                       out_vld,
  output qrs_pkg::dv_side_t          out_side,
  output logic [qrs_pkg::NUM_W-1:0]  out_quo1,
  output logic [qrs_pkg::NUM_W-1:0]  out_quo2
);
  import qrs_pkg::*;

  // Restoring division, one quotient bit per stage, two lanes sharing a divisor.
  logic             vld_r  [NUM_W];
  dv_side_t         side_r [NUM_W];
  logic [DEN_W-1:0] den_r  [NUM_W];
  dv_lane_t         l1_r   [NUM_W];
  dv_lane_t         l2_r   [NUM_W];

  function automatic dv_lane_t div_step(dv_lane_t l, logic [DEN_W-1:0] den, int bit_idx);
    logic [DEN_W:0] sh;
    dv_lane_t       o;
    sh    = {l.rem, l.num[bit_idx]};
    o     = l;
    if (sh >= {1'b0, den}) begin
      sh           = sh - {1'b0, den};
      o.quo[bit_idx] = 1'b1;
    end
    o.rem = sh[DEN_W-1:0];
    return o;
  endfunction

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    localparam int BIT = NUM_W - 1 - j;
    logic             vld_i;
    dv_side_t         side_i;
    logic [DEN_W-1:0] den_i;
    dv_lane_t         l1_i, l2_i;

    if (j == 0) begin : g_first
      assign vld_i  = in_vld;
      assign side_i = in_side;
      assign den_i  = in_den;
      assign l1_i   = '{rem: '0, quo: '0, num: in_num1};
      assign l2_i   = '{rem: '0, quo: '0, num: in_num2};
    end else begin : g_next
      assign vld_i  = vld_r[j-1];
      assign side_i = side_r[j-1];
      assign den_i  = den_r[j-1];
      assign l1_i   = l1_r[j-1];
      assign l2_i   = l2_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= side_i;
        den_r[j]  <= den_i;
        l1_r[j]   <= div_step(l1_i, den_i, BIT);
        l2_r[j]   <= div_step(l2_i, den_i, BIT);
      end
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];
  assign out_quo1 = l1_r[NUM_W-1].quo;
  assign out_quo2 = l2_r[NUM_W-1].quo;

endmodule

// File: design/quadratic_root_solver.sv
// Quadratic root solver: real roots of a*x^2 + b*x + c = 0 in signed Q16.16.
//
// cfg_ch writes zero_tolerance (always ready); write it only while no item is in flight.
// in_ch takes one item of coefficients a, b, c on valid and ready; out_ch returns one
// item per input: root count, first and second root and a saturation flag.
//
// The datapath is one pipeline that advances as a whole: three front stages (magnitudes,
// two 32x32 products, discriminant and case), 33 square root stages (one root bit each),
// one stage that forms the numerators and divisor, 50 divider stages (one quotient bit
// each, two lanes), and the output register. One item can enter every cycle while
// out_ch does not hold the pipeline.
//
// When the receiver holds out_ch.ready low with a result waiting, the whole pipeline
// holds and in_ch.ready drops in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears the tolerance to zero and empties every stage.
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver (
  input  logic        clk,
  input  logic        rst_n,
  qrs_cfg_if.sink     cfg_ch,
  qrs_in_if.sink      in_ch,
  qrs_out_if.source   out_ch
);
  import qrs_pkg::*;

  logic [TOL_W-1:0]  tol_r;
  logic              en;
  logic              fr_vld, sq_vld, dv_vld;
  sq_side_t          fr_side, sq_side;
  logic [D_W-1:0]    fr_dm;
  logic [SQ_W-1:0]   sq_root;
  dv_side_t          dv_side, p_side_r, p_side_nxt;
  logic [NUM_W-1:0]  dv_q1, dv_q2;
  logic              p_vld_r;
  logic [NUM_W-1:0]  p_num1_r, p_num2_r, p_num1_nxt, p_num2_nxt;
  logic [DEN_W-1:0]  p_den_r, p_den_nxt;
  logic signed [N_W:0] sx, bmag, bs, n1, n2;
  logic [N_W:0]      m1, m2;
  logic [COEF_W:0]   c1, c2;
  logic              out_vld_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [COEF_W-1:0] r1_r, r2_r;
  logic              sat_r;

  // Tolerance register.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.zero_tolerance;
    end
  end

  // The pipeline moves whenever the output register is empty or being taken.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_ch.valid),
    .coef_a   (in_ch.coef_a),
    .coef_b   (in_ch.coef_b),
    .coef_c   (in_ch.coef_c),
    .tol      (tol_r),
    .out_vld  (fr_vld),
    .out_side (fr_side),
    .out_dm   (fr_dm)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_rad   (fr_dm),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // Numerators (-b +/- sqrt(D) for two roots) and the divisor for each case.
  assign sx   = signed'((N_W + 1)'(sq_root));
  assign bmag = signed'((N_W + 1)'(sq_side.mb));
  assign bs   = sq_side.sb ? -bmag : bmag;
  assign n1   = sx - bs;
  assign n2   = -sx - bs;
  assign m1   = n1[N_W] ? -n1 : n1;
  assign m2   = n2[N_W] ? -n2 : n2;

  always_comb begin
    p_side_nxt.cnt  = sq_side.cnt;
    p_side_nxt.neg1 = 1'b0;
    p_side_nxt.neg2 = 1'b0;
    p_num1_nxt      = '0;
    p_num2_nxt      = '0;
    p_den_nxt       = DEN_W'(1);
    unique case (sq_side.mode)
      M_LIN: begin
        p_side_nxt.neg1 = (sq_side.sb == sq_side.sc);
        p_num1_nxt      = NUM_W'(sq_side.mc) << FRAC_BITS;
        p_den_nxt       = DEN_W'(sq_side.mb);
      end
      M_ONE: begin
        p_side_nxt.neg1 = (sq_side.sa == sq_side.sb);
        p_num1_nxt      = NUM_W'(sq_side.mb) << FRAC_BITS;
        p_den_nxt       = {sq_side.ma, 1'b0};
      end
      M_TWO: begin
        p_side_nxt.neg1 = (n1[N_W] != sq_side.sa);
        p_side_nxt.neg2 = (n2[N_W] != sq_side.sa);
        p_num1_nxt      = NUM_W'(m1[N_W-1:0]) << FRAC_BITS;
        p_num2_nxt      = NUM_W'(m2[N_W-1:0]) << FRAC_BITS;
        p_den_nxt       = {sq_side.ma, 1'b0};
      end
      default: begin
        p_den_nxt = DEN_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side_r <= p_side_nxt;
      p_num1_r <= p_num1_nxt;
      p_num2_r <= p_num2_nxt;
      p_den_r  <= p_den_nxt;
    end
  end

  qrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (p_vld_r),
    .in_side  (p_side_r),
    .in_num1  (p_num1_r),
    .in_num2  (p_num2_r),
    .in_den   (p_den_r),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quo1 (dv_q1),
    .out_quo2 (dv_q2)
  );

  // Output register: clamp, apply signs, merge the saturation flags.
  assign c1 = clamp_root(dv_side.neg1, dv_q1);
  assign c2 = clamp_root(dv_side.neg2, dv_q2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r <= dv_side.cnt;
      r1_r  <= c1[COEF_W-1:0];
      r2_r  <= c2[COEF_W-1:0];
      sat_r <= c1[COEF_W] | c2[COEF_W];
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.root_count  = cnt_r;
  assign out_ch.root_first  = signed'(r1_r);
  assign out_ch.root_second = signed'(r2_r);
  assign out_ch.saturated   = sat_r;

  // A result without a computed root carries zeros and no saturation.
  `QRS_ASSERT(a_none_zero, out_ch.valid && (out_ch.root_count == CNT_NONE || out_ch.root_count == CNT_INF) |-> out_ch.root_first == 0 && !out_ch.saturated, "root reported for a case without roots")
  // The second root is only present with two roots.
  `QRS_ASSERT(a_second_zero, out_ch.valid && out_ch.root_count != CNT_TWO |-> out_ch.root_second == 0, "second root nonzero without two roots")
  // Reset empties the pipeline.
  `QRS_ASSERT_ANY(a_reset_idle, !rst_n |=> !out_ch.valid && !p_vld_r, "pipeline not empty after reset")

endmodule
